>>> rtl/stt_pkg.sv
// Shared types and constants for the timer slot table.
package stt_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = 16;
    localparam int ID_W      = 4;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_POLL     = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        K_REGISTERED = 3'd0,
        K_FULL       = 3'd1,
        K_REMOVED    = 3'd2,
        K_IGNORED    = 3'd3,
        K_TICKED     = 3'd4,
        K_EXPIRED    = 3'd5,
        K_NONE       = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One table entry: the period and the global tick count at the last clear.
    typedef struct packed {
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] base;
    } entry_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   slot_id;
        logic              last;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } ram_req_t;

endpackage

>>> rtl/software_timer_slot_table_core.sv
// Top level of the periodic timer slot table with its output register.
// A register, remove or tick item passes the engine's EMIT state and the output register
// before its result shows on m_tvalid. A poll holds each expiry until the next one is found
// or the scan ends. No new item is taken until the last result is handed on; a poll scans
// one entry per cycle via the RAM read port unless a held expiry waits on a full output
// register. Reset (aresetn low at a clock edge) frees every slot, clears the global tick
// count and drops any held result; the table RAM keeps its contents.
module software_timer_slot_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata fields from bit 0: period [15:0], slot [19:16], zero fill [23:20].
    input  logic [stt_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser fields from bit 0: op [1:0].
    input  logic [stt_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata fields from bit 0: slot_id [3:0], zero fill [7:4].
    output logic [stt_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser fields from bit 0: kind [2:0].
    output logic [stt_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import stt_pkg::*;

    // The engine works on one item at a time. Its held result and this output register
    // decouple it from the result side, so a new item is taken while a result still waits.
    // The table RAM needs no clearing pass, since only entries of slots in use ever matter.
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    ram_req_t ram_req;
    entry_t   ram_rdata;
    logic [$bits(entry_t)-1:0] ram_rdata_raw;

    logic             m_tvalid_reg;
    kind_t            m_kind_reg;
    logic [ID_W-1:0]  m_id_reg;
    logic             m_last_reg;

    // Each table entry holds a period and the global tick count at which the slot's
    // own count was last cleared; the slot's count is the difference of the two.
    stt_ram #(
        .DEPTH (SLOTS),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    stt_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (op_t'(s_tuser)),
        .in_period (s_tdata[15:0]),
        .in_slot   (s_tdata[19:16]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // The output register takes a new item whenever it is empty or being emptied.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_kind_reg <= res.kind;
            m_id_reg   <= res.slot_id;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W){1'b0}}, m_id_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/stt_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module stt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while the read enable is low.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/stt_engine.sv
// Command sequencer: slot allocation, tick count and the expiry scan over the table RAM.
module stt_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  stt_pkg::op_t      in_op,
    input  logic [15:0]       in_period,
    input  logic [3:0]        in_slot,
    output logic              res_valid,
    input  logic              res_ready,
    output stt_pkg::res_t     res,
    output stt_pkg::ram_req_t ram_req,
    input  stt_pkg::entry_t   ram_rdata
);
    import stt_pkg::*;

    state_t             state_reg, state_next;
    logic [SLOTS-1:0]   in_use_reg, in_use_next;
    logic [CNT_W-1:0]   now_reg, now_next;
    logic               pend_valid_reg, pend_valid_next;
    kind_t              pend_kind_reg, pend_kind_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic               issued_all_reg, issued_all_next;
    logic               valid_b_reg, valid_b_next;
    logic [SLOT_W-1:0]  idx_b_reg, idx_b_next;

    logic               free_found;
    logic [SLOT_W-1:0]  free_idx;
    logic               hit;
    logic               stall;
    logic [CNT_W-1:0]   elapsed;
    logic [SLOT_W-1:0]  rm_idx;
    logic               rm_in_range;

    // Lowest free slot from 1 upward.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 1; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign rm_idx      = SLOT_W'(in_slot);
    assign rm_in_range = 32'(in_slot) < SLOTS;

    // Tick count of an entry is the global count minus its base, modulo 2^16.
    assign elapsed = now_reg - ram_rdata.base;
    assign hit     = (state_reg == ST_SCAN) && valid_b_reg && in_use_reg[idx_b_reg]
                     && (elapsed >= ram_rdata.period);
    assign stall   = hit && pend_valid_reg && !res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
            issued_all_reg <= 1'b0;
            valid_b_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
            issued_all_reg <= issued_all_next;
            valid_b_reg    <= valid_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_id_reg   <= pend_id_next;
        idx_reg       <= idx_next;
        idx_b_reg     <= idx_b_next;
    end

    always_comb begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        now_next        = now_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        idx_next        = idx_reg;
        issued_all_next = issued_all_reg;
        valid_b_next    = valid_b_reg;
        idx_b_next      = idx_b_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        res             = '{kind: pend_kind_reg, slot_id: pend_id_reg, last: 1'b1};
        ram_req         = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    pend_valid_next = 1'b1;
                    state_next      = ST_EMIT;
                    case (in_op)
                        OP_REGISTER: begin
                            if (free_found) begin
                                in_use_next[free_idx] = 1'b1;
                                ram_req.we            = 1'b1;
                                ram_req.waddr         = free_idx;
                                ram_req.wdata         = '{period: in_period, base: now_reg};
                                pend_kind_next        = K_REGISTERED;
                                pend_id_next          = ID_W'(free_idx);
                            end else begin
                                pend_kind_next = K_FULL;
                                pend_id_next   = '0;
                            end
                        end
                        OP_REMOVE: begin
                            pend_id_next = in_slot;
                            if (rm_in_range) begin
                                in_use_next[rm_idx] = 1'b0;
                                pend_kind_next      = K_REMOVED;
                            end else begin
                                pend_kind_next = K_IGNORED;
                            end
                        end
                        OP_TICK: begin
                            now_next       = now_reg + 1'b1;
                            pend_kind_next = K_TICKED;
                            pend_id_next   = '0;
                        end
                        default: begin
                            pend_valid_next = 1'b0;
                            idx_next        = '0;
                            issued_all_next = 1'b0;
                            valid_b_next    = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // A new expiry pushes the held one out; it cannot be the last.
                if (hit && pend_valid_reg) begin
                    res_valid = 1'b1;
                    res.last  = 1'b0;
                end
                if (!stall) begin
                    if (hit) begin
                        pend_valid_next = 1'b1;
                        pend_kind_next  = K_EXPIRED;
                        pend_id_next    = ID_W'(idx_b_reg);
                        ram_req.we      = 1'b1;
                        ram_req.waddr   = idx_b_reg;
                        ram_req.wdata   = '{period: ram_rdata.period, base: now_reg};
                    end
                    if (!issued_all_reg) begin
                        ram_req.re   = 1'b1;
                        ram_req.raddr = idx_reg;
                        valid_b_next = 1'b1;
                        idx_b_next   = idx_reg;
                        idx_next     = idx_reg + 1'b1;
                        if (idx_reg == LAST_SLOT) begin
                            issued_all_next = 1'b1;
                        end
                    end else begin
                        valid_b_next = 1'b0;
                    end
                    if (valid_b_reg && idx_b_reg == LAST_SLOT) begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH: begin
                res_valid = 1'b1;
                if (!pend_valid_reg) begin
                    res = '{kind: K_NONE, slot_id: '0, last: 1'b1};
                end
                if (res_ready) begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_slot0_never_used: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_use_reg[0])
        else $error("slot 0 was handed out");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> !pend_valid_reg)
        else $error("pending result left over while idle");

    a_scan_write_sets_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.we && state_reg == ST_SCAN) |=> pend_valid_reg)
        else $error("expiry clear without a held result");

    a_stall_holds_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> !ram_req.re && !ram_req.we)
        else $error("table accessed during a stalled scan");

endmodule
